/* design/clock_time_set_controller_defines.svh */
// assertion macros shared by the checker
`ifndef CLOCK_TIME_SET_CONTROLLER_DEFINES_SVH
`define CLOCK_TIME_SET_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CTSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctsc same-cycle check failed");

// next-cycle implication, disabled in reset
`define CTSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctsc next-cycle check failed");

`endif

/* design/ctsc_pkg.sv */
`default_nettype none

package ctsc_pkg;

    localparam logic CMD_BUTTON = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic [1:0] BTN_STEP   = 2'd0;
    localparam logic [1:0] BTN_ADJUST = 2'd1;

    localparam logic [1:0] PRESS_SHORT = 2'd0;
    localparam logic [1:0] PRESS_LONG  = 2'd1;
    localparam logic [1:0] PRESS_HOLD  = 2'd2;

    localparam logic [2:0] FIELD_HOURS   = 3'd0;
    localparam logic [2:0] FIELD_MINUTES = 3'd1;
    localparam logic [2:0] FIELD_YEAR    = 3'd2;
    localparam logic [2:0] FIELD_MONTH   = 3'd3;
    localparam logic [2:0] FIELD_DAY     = 3'd4;

    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [5:0] MINUTES_MAX = 6'd59;
    localparam logic [4:0] DAY_MIN     = 5'd1;
    localparam logic [3:0] MONTH_MIN   = 4'd1;
    localparam logic [3:0] MONTH_MAX   = 4'd12;
    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [4:0] FEB_LEAP    = 5'd29;
    localparam logic [3:0] MONTH_FEB   = 4'd2;

    // unused month codes read as 31
    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef struct packed {
        logic       command;
        logic [1:0] button;
        logic [1:0] press;
        logic [4:0] load_hours;
        logic [5:0] load_minutes;
        logic [4:0] load_day;
        logic [3:0] load_month;
        logic [6:0] load_year;
    } ctsc_item_t;

    typedef struct packed {
        logic       setup_mode;
        logic [2:0] field_step;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } ctsc_state_t;

    typedef struct packed {
        logic taken;
        logic write;
    } ctsc_flags_t;

    localparam ctsc_state_t STATE_RESET = '{
        setup_mode: 1'b0,
        field_step: FIELD_HOURS,
        hours:      5'd0,
        minutes:    6'd0,
        day:        5'd1,
        month:      4'd1,
        year:       7'd0
    };

    // leap year when year mod 4 is 0
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [6:0] y);
        logic [4:0] len;
        len = MONTH_LEN[m];
        if (m == MONTH_FEB && y[1:0] == 2'b00)
        begin
            len = FEB_LEAP;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

/* design/ctsc_update.sv */
`default_nettype none

module ctsc_update
    import ctsc_pkg::*;
(
    input  wire ctsc_item_t  item,
    input  wire ctsc_state_t state_cur,
    output ctsc_state_t      state_next,
    output ctsc_flags_t      flags
);

    logic [4:0] dim;
    logic [5:0] day_inc;
    logic [4:0] month_inc;

    always_comb
    begin
        dim        = days_in_month(state_cur.month, state_cur.year);
        day_inc    = {1'b0, state_cur.day} + 6'd1;
        month_inc  = {1'b0, state_cur.month} + 5'd1;
        state_next = state_cur;
        flags      = '0;

        if (item.command == CMD_LOAD)
        begin
            // loads are ignored while the user edits
            if (!state_cur.setup_mode)
            begin
                state_next.hours   = (item.load_hours > HOURS_MAX) ? HOURS_MAX
                                                                   : item.load_hours;
                state_next.minutes = (item.load_minutes > MINUTES_MAX) ? MINUTES_MAX
                                                                       : item.load_minutes;
                state_next.day     = (item.load_day < DAY_MIN) ? DAY_MIN : item.load_day;
                if (item.load_month < MONTH_MIN)
                begin
                    state_next.month = MONTH_MIN;
                end
                else if (item.load_month > MONTH_MAX)
                begin
                    state_next.month = MONTH_MAX;
                end
                else
                begin
                    state_next.month = item.load_month;
                end
                state_next.year    = (item.load_year > YEAR_MAX) ? YEAR_MAX : item.load_year;
            end
        end
        else if (!state_cur.setup_mode)
        begin
            if (item.button == BTN_STEP && item.press == PRESS_LONG)
            begin
                state_next.setup_mode = 1'b1;
                flags.taken           = 1'b1;
            end
        end
        else if (item.button == BTN_STEP)
        begin
            if (item.press == PRESS_SHORT)
            begin
                flags.taken = 1'b1;
                case (state_cur.field_step)
                    FIELD_HOURS:   state_next.field_step = FIELD_MINUTES;
                    FIELD_MINUTES: state_next.field_step = FIELD_YEAR;
                    FIELD_YEAR:    state_next.field_step = FIELD_MONTH;
                    FIELD_MONTH:
                    begin
                        state_next.field_step = FIELD_DAY;
                        if (state_cur.day > dim)
                        begin
                            state_next.day = dim;
                        end
                    end
                    FIELD_DAY:
                    begin
                        state_next.field_step = FIELD_HOURS;
                        state_next.setup_mode = 1'b0;
                        flags.write           = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        else if (item.button == BTN_ADJUST)
        begin
            if (item.press == PRESS_SHORT || item.press == PRESS_HOLD)
            begin
                flags.taken = 1'b1;
                case (state_cur.field_step)
                    FIELD_HOURS:
                        state_next.hours = (state_cur.hours >= HOURS_MAX) ? 5'd0
                                           : state_cur.hours + 5'd1;
                    FIELD_MINUTES:
                        state_next.minutes = (state_cur.minutes >= MINUTES_MAX) ? 6'd0
                                             : state_cur.minutes + 6'd1;
                    FIELD_YEAR:
                        state_next.year = (state_cur.year >= YEAR_MAX) ? 7'd0
                                          : state_cur.year + 7'd1;
                    FIELD_MONTH:
                        state_next.month = (month_inc > {1'b0, MONTH_MAX}) ? MONTH_MIN
                                           : month_inc[3:0];
                    FIELD_DAY:
                        state_next.day = (day_inc > {1'b0, dim}) ? DAY_MIN : day_inc[4:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* design/clock_time_set_controller.sv */
// channel   direction   handshake            payload
// input     in          in_valid/in_stall    command, button, press, load_*
// output    out         out_valid/out_stall  in_setup, setup_field, button_taken,
//                                            write_clock, shown_*
//
// one item per cycle sustained while the result is not stalled; the item is registered first, then its result
// the item register feeds the update logic, whose result and new state load together
// the input stalls only when the item register is full and the result is stalled
// reset returns to running mode, hours field, time 00:00, day 1, month 1, year 0
`default_nettype none

module clock_time_set_controller
    import ctsc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire        command,
    input  wire  [1:0] button,
    input  wire  [1:0] press,
    input  wire  [4:0] load_hours,
    input  wire  [5:0] load_minutes,
    input  wire  [4:0] load_day,
    input  wire  [3:0] load_month,
    input  wire  [6:0] load_year,
    output logic       out_valid,
    input  wire        out_stall,
    output logic       in_setup,
    output logic [2:0] setup_field,
    output logic       button_taken,
    output logic       write_clock,
    output logic [4:0] shown_hours,
    output logic [5:0] shown_minutes,
    output logic [4:0] shown_day,
    output logic [3:0] shown_month,
    output logic [6:0] shown_year
);

    ctsc_item_t  item_reg;
    logic        item_valid_reg;
    ctsc_state_t state_reg;
    ctsc_state_t state_next;
    ctsc_flags_t flags_next;
    ctsc_state_t res_state_reg;
    ctsc_flags_t res_flags_reg;
    logic        out_valid_reg;
    logic        advance;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = item_valid_reg && !advance;

    ctsc_update u_update (
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .flags      (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= item_valid_reg;
                if (item_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= '{
                command:      command,
                button:       button,
                press:        press,
                load_hours:   load_hours,
                load_minutes: load_minutes,
                load_day:     load_day,
                load_month:   load_month,
                load_year:    load_year
            };
        end
        if (advance && item_valid_reg)
        begin
            res_state_reg <= state_next;
            res_flags_reg <= flags_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign in_setup      = res_state_reg.setup_mode;
    assign setup_field   = res_state_reg.field_step;
    assign button_taken  = res_flags_reg.taken;
    assign write_clock   = res_flags_reg.write;
    assign shown_hours   = res_state_reg.hours;
    assign shown_minutes = res_state_reg.minutes;
    assign shown_day     = res_state_reg.day;
    assign shown_month   = res_state_reg.month;
    assign shown_year    = res_state_reg.year;

endmodule

`default_nettype wire

/* design/ctsc_checker.sv */
`default_nettype none
`include "clock_time_set_controller_defines.svh"

module ctsc_checker
    import ctsc_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       in_stall,
    input wire       out_valid,
    input wire       out_stall,
    input wire       in_setup,
    input wire [2:0] setup_field,
    input wire       button_taken,
    input wire       write_clock,
    input wire [4:0] shown_hours,
    input wire [5:0] shown_minutes,
    input wire [4:0] shown_day,
    input wire [3:0] shown_month,
    input wire [6:0] shown_year
);

    logic        write_seen;
    logic        ranges_ok;
    logic        out_held;
    logic [32:0] out_view;

    assign write_seen = out_valid && write_clock;
    assign out_held   = out_valid && out_stall;
    assign ranges_ok  = shown_day >= DAY_MIN && shown_month >= MONTH_MIN
                        && shown_month <= MONTH_MAX && shown_hours <= HOURS_MAX
                        && shown_minutes <= MINUTES_MAX && shown_year <= YEAR_MAX;
    assign out_view   = {in_setup, setup_field, button_taken, write_clock, shown_hours,
                         shown_minutes, shown_day, shown_month, shown_year};

    // a clock write closes setup and comes from a taken press
    `CTSC_ASSERT_IMP(a_write_ends_setup, clk, rst_n, write_seen, !in_setup && button_taken)

    // running mode always sits on the hours field
    `CTSC_ASSERT_IMP(a_run_on_hours, clk, rst_n, out_valid && !in_setup, setup_field == FIELD_HOURS)

    // held calendar values stay in range
    `CTSC_ASSERT_IMP(a_date_range, clk, rst_n, out_valid, ranges_ok)

    // a stalled result holds
    `CTSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_view))

    // the input stalls only behind a stalled result
    `CTSC_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind clock_time_set_controller ctsc_checker u_ctsc_checker (.*);

`default_nettype wire

/* sim/clock_time_set_controller_checker.sv */
module clock_time_set_controller_checker
    import ctsc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_stall,
    input  wire        command,
    input  wire  [1:0] button,
    input  wire  [1:0] press,
    input  wire  [4:0] load_hours,
    input  wire  [5:0] load_minutes,
    input  wire  [4:0] load_day,
    input  wire  [3:0] load_month,
    input  wire  [6:0] load_year,
    input  wire        out_valid,
    input  wire        out_stall,
    input  wire        in_setup,
    input  wire  [2:0] setup_field,
    input  wire        button_taken,
    input  wire        write_clock,
    input  wire  [4:0] shown_hours,
    input  wire  [5:0] shown_minutes,
    input  wire  [4:0] shown_day,
    input  wire  [3:0] shown_month,
    input  wire  [6:0] shown_year,
    output int         mismatches,
    output int         awaiting
);

    typedef struct packed {
        logic       setup_on;
        logic [2:0] field;
        logic       taken;
        logic       write;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } clock_view_t;

    clock_view_t expected_views[$];

    logic       setup_on;
    logic [2:0] step_field;
    logic [4:0] time_hours;
    logic [5:0] time_minutes;
    logic [4:0] time_day;
    logic [3:0] time_month;
    logic [6:0] time_year;

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
        case (m)
            4'd2:                     return (y % 4 == 0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  return 5'd30;
            default:                  return 5'd31;
        endcase
    endfunction

    function automatic string view_text(input clock_view_t v);
        return $sformatf("setup=%0d field=%0d taken=%0d write=%0d time=%0d:%0d date=%0d/%0d/%0d",
            v.setup_on, v.field, v.taken, v.write, v.hours, v.minutes, v.day, v.month,
            v.year);
    endfunction

    function automatic clock_view_t advance_clock_state(input ctsc_item_t it);
        clock_view_t v;
        logic        taken;
        logic        wr;
        logic [4:0]  dim;
        taken = 1'b0;
        wr = 1'b0;
        if (it.command == CMD_LOAD)
        begin
            // loads only land while running, clipped into range
            if (!setup_on)
            begin
                time_hours = (it.load_hours > HOURS_MAX) ? HOURS_MAX : it.load_hours;
                time_minutes = (it.load_minutes > MINUTES_MAX) ? MINUTES_MAX : it.load_minutes;
                time_day = (it.load_day < DAY_MIN) ? DAY_MIN : it.load_day;
                if (it.load_month < MONTH_MIN)
                    time_month = MONTH_MIN;
                else if (it.load_month > MONTH_MAX)
                    time_month = MONTH_MAX;
                else
                    time_month = it.load_month;
                time_year = (it.load_year > YEAR_MAX) ? YEAR_MAX : it.load_year;
            end
        end
        else if (!setup_on)
        begin
            if (it.button == BTN_STEP && it.press == PRESS_LONG)
            begin
                setup_on = 1'b1;
                taken = 1'b1;
            end
        end
        else if (it.button == BTN_STEP)
        begin
            if (it.press == PRESS_SHORT)
            begin
                taken = 1'b1;
                case (step_field)
                    FIELD_HOURS:   step_field = FIELD_MINUTES;
                    FIELD_MINUTES: step_field = FIELD_YEAR;
                    FIELD_YEAR:    step_field = FIELD_MONTH;
                    FIELD_MONTH:
                    begin
                        step_field = FIELD_DAY;
                        dim = month_length(time_month, time_year);
                        if (time_day > dim)
                            time_day = dim;
                    end
                    FIELD_DAY:
                    begin
                        step_field = FIELD_HOURS;
                        setup_on = 1'b0;
                        wr = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        else if (it.button == BTN_ADJUST)
        begin
            if (it.press == PRESS_SHORT || it.press == PRESS_HOLD)
            begin
                taken = 1'b1;
                case (step_field)
                    FIELD_HOURS:
                        time_hours = (time_hours >= HOURS_MAX) ? 5'd0 : time_hours + 5'd1;
                    FIELD_MINUTES:
                        time_minutes = (time_minutes >= MINUTES_MAX) ? 6'd0 : time_minutes + 6'd1;
                    FIELD_YEAR:
                        time_year = (time_year >= YEAR_MAX) ? 7'd0 : time_year + 7'd1;
                    FIELD_MONTH:
                        time_month = (time_month >= MONTH_MAX) ? MONTH_MIN : time_month + 4'd1;
                    FIELD_DAY:
                    begin
                        dim = month_length(time_month, time_year);
                        if (int'(time_day) + 1 > int'(dim))
                            time_day = DAY_MIN;
                        else
                            time_day = time_day + 5'd1;
                    end
                    default: ;
                endcase
            end
        end
        v = {setup_on, step_field, taken, wr, time_hours, time_minutes, time_day, time_month,
             time_year};
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clock_view_t got;
        clock_view_t want;
        ctsc_item_t  item;
        if (!rst_n)
        begin
            setup_on = 1'b0;
            step_field = FIELD_HOURS;
            time_hours = '0;
            time_minutes = '0;
            time_day = DAY_MIN;
            time_month = MONTH_MIN;
            time_year = '0;
            expected_views.delete();
            awaiting = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {in_setup, setup_field, button_taken, write_clock, shown_hours,
                       shown_minutes, shown_day, shown_month, shown_year};
                if (expected_views.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: %s", view_text(got));
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected %s, got %s", view_text(want),
                                     view_text(got));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                item = {command, button, press, load_hours, load_minutes, load_day,
                        load_month, load_year};
                expected_views.push_back(advance_clock_state(item));
            end
            awaiting = expected_views.size();
        end
    end

endmodule

/* sim/clock_time_set_controller_tb.sv */
module clock_time_set_controller_tb;
    import ctsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int DIRECTED_ITEMS = 25;

    localparam logic [1:0] BTN_OTHER   = 2'd2;
    localparam logic [1:0] BTN_SPARE   = 2'd3;
    localparam logic [1:0] PRESS_OTHER = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       command = 1'b0;
    logic [1:0] button = 2'd0;
    logic [1:0] press = 2'd0;
    logic [4:0] load_hours = 5'd0;
    logic [5:0] load_minutes = 6'd0;
    logic [4:0] load_day = 5'd1;
    logic [3:0] load_month = 4'd1;
    logic [6:0] load_year = 7'd0;
    logic       out_stall = 1'b0;

    wire        in_stall;
    wire        out_valid;
    wire        in_setup;
    wire  [2:0] setup_field;
    wire        button_taken;
    wire        write_clock;
    wire  [4:0] shown_hours;
    wire  [5:0] shown_minutes;
    wire  [4:0] shown_day;
    wire  [3:0] shown_month;
    wire  [6:0] shown_year;

    int mismatches;
    int awaiting;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    clock_time_set_controller dut (.*);

    clock_time_set_controller_checker time_check (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("clock_time_set_controller verification failed");
            $finish;
        end
    end

    function automatic ctsc_item_t make_item(input logic cmd, input logic [1:0] b,
                                             input logic [1:0] p, input logic [4:0] h,
                                             input logic [5:0] m, input logic [4:0] d,
                                             input logic [3:0] mo, input logic [6:0] y);
        ctsc_item_t it;
        it = {cmd, b, p, h, m, d, mo, y};
        return it;
    endfunction

    function automatic ctsc_item_t button_item(input logic [1:0] b, input logic [1:0] p);
        return make_item(CMD_BUTTON, b, p, 5'($urandom_range(31)), 6'($urandom_range(63)),
                         5'($urandom_range(31)), 4'($urandom_range(15)),
                         7'($urandom_range(127)));
    endfunction

    function automatic ctsc_item_t load_item();
        if ($urandom_range(4) != 0)
            return make_item(CMD_LOAD, 2'($urandom_range(3)), 2'($urandom_range(3)),
                             5'($urandom_range(23)), 6'($urandom_range(59)),
                             5'($urandom_range(31, 1)), 4'($urandom_range(12, 1)),
                             7'($urandom_range(99)));
        return make_item(CMD_LOAD, 2'($urandom_range(3)), 2'($urandom_range(3)),
                         5'($urandom_range(31)), 6'($urandom_range(63)),
                         5'($urandom_range(31)), 4'($urandom_range(15)),
                         7'($urandom_range(127)));
    endfunction

    function automatic ctsc_item_t noise_item();
        return make_item(1'($urandom_range(1)), 2'($urandom_range(3)), 2'($urandom_range(3)),
                         5'($urandom_range(31)), 6'($urandom_range(63)),
                         5'($urandom_range(31)), 4'($urandom_range(15)),
                         7'($urandom_range(127)));
    endfunction

    task automatic send_item(input ctsc_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= it.command;
        button <= it.button;
        press <= it.press;
        load_hours <= it.load_hours;
        load_minutes <= it.load_minutes;
        load_day <= it.load_day;
        load_month <= it.load_month;
        load_year <= it.load_year;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_with_noise(input ctsc_item_t it);
        if ($urandom_range(99) < 12)
            send_item(noise_item());
        send_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // one pass through setup: optional load, enter, adjust each field, step on
    task automatic run_session();
        int f;
        int n;
        if ($urandom_range(3) != 0)
            send_with_noise(load_item());
        send_with_noise(button_item(BTN_STEP, PRESS_LONG));
        for (f = 0; f < 5; f++)
        begin
            n = ($urandom_range(3) == 0) ? int'($urandom_range(70)) : int'($urandom_range(5));
            repeat (n)
                send_with_noise(button_item(BTN_ADJUST,
                                            $urandom_range(1) ? PRESS_SHORT : PRESS_HOLD));
            send_with_noise(button_item(BTN_STEP, PRESS_SHORT));
        end
    endtask

    initial
    begin
        send_idle_pct = 20;
        stall_pct = 51;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_item(make_item(CMD_LOAD, BTN_SPARE, PRESS_OTHER, 5'd31, 6'd63, 5'd0, 4'd15, 7'd127));
        send_item(make_item(CMD_LOAD, BTN_STEP, PRESS_LONG, 5'd0, 6'd0, 5'd0, 4'd0, 7'd0));
        send_item(make_item(CMD_LOAD, BTN_ADJUST, PRESS_SHORT, 5'd23, 6'd59, 5'd31, 4'd1,
                            7'd99));
        send_item(button_item(BTN_OTHER, PRESS_LONG));
        send_item(button_item(BTN_SPARE, PRESS_SHORT));
        send_item(button_item(BTN_ADJUST, PRESS_SHORT));
        send_item(button_item(BTN_STEP, PRESS_SHORT));
        send_item(button_item(BTN_STEP, PRESS_HOLD));
        send_item(button_item(BTN_STEP, PRESS_LONG));
        // load while setting is dropped
        send_item(make_item(CMD_LOAD, BTN_STEP, PRESS_SHORT, 5'd5, 6'd5, 5'd5, 4'd5, 7'd5));
        send_item(button_item(BTN_STEP, PRESS_LONG));
        send_item(button_item(BTN_STEP, PRESS_OTHER));
        send_item(button_item(BTN_ADJUST, PRESS_LONG));
        send_item(button_item(BTN_ADJUST, PRESS_SHORT));
        send_item(button_item(BTN_ADJUST, PRESS_HOLD));
        send_item(button_item(BTN_STEP, PRESS_SHORT));
        send_item(button_item(BTN_ADJUST, PRESS_SHORT));
        send_item(button_item(BTN_STEP, PRESS_SHORT));
        send_item(button_item(BTN_ADJUST, PRESS_SHORT));
        send_item(button_item(BTN_STEP, PRESS_SHORT));
        send_item(button_item(BTN_ADJUST, PRESS_SHORT));
        // leaving month with day 31 in a leap february
        send_item(button_item(BTN_STEP, PRESS_SHORT));
        send_item(button_item(BTN_ADJUST, PRESS_HOLD));
        send_item(button_item(BTN_STEP, PRESS_SHORT));
        send_item(button_item(BTN_OTHER, PRESS_SHORT));

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS / 3)
            run_session();
        wait_drained();

        send_idle_pct = 51;
        stall_pct = 20;
        while (items_sent < DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3)
            run_session();
        wait_drained();

        send_idle_pct = 0;
        stall_pct = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
            run_session();
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && awaiting == 0)
            $display("clock_time_set_controller verification clean");
        else
            $display("clock_time_set_controller verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/ctsc_pkg.sv
design/ctsc_update.sv
design/clock_time_set_controller.sv
design/ctsc_checker.sv
sim/clock_time_set_controller_checker.sv
sim/clock_time_set_controller_tb.sv
